// ===== hw/rtl/glmf_pkg.sv =====
`default_nettype none
package glmf_pkg;

	localparam int MAX_ROWS    = 32;
	localparam int MAX_COLS    = 32;
	localparam int VALUE_WIDTH = 16;
	localparam int ROW_W       = 5;
	localparam int COL_W       = 5;
	localparam int CNT_W       = 6;
	localparam int FIFO_DEPTH  = 8;
	localparam int FIFO_PTR_W  = 3;
	localparam int FIFO_CNT_W  = 4;
	localparam int RES_PER_IN  = 3;

	typedef enum logic {
		REG_ROW_COUNT = 1'b0,
		REG_COL_COUNT = 1'b1
	} reg_index_t;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;

	typedef struct packed {
		logic [ROW_W-1:0] cell_row;
		logic [COL_W-1:0] cell_col;
		logic             is_peak;
		logic             last_of_run;
		logic             grid_end;
	} result_t;

	typedef struct packed {
		logic [RES_PER_IN-1:0]          valid;
		result_t [RES_PER_IN-1:0]       entry;
	} push_t;

	typedef struct packed {
		logic [FIFO_CNT_W-1:0] fill;
	} fifo_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/glmf_in_if.sv =====
`default_nettype none
interface glmf_in_if import glmf_pkg::*; ();
	logic   valid;
	logic   ready;
	value_t value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/glmf_out_if.sv =====
`default_nettype none
interface glmf_out_if import glmf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] cell_row;
	logic [COL_W-1:0] cell_col;
	logic             is_peak;
	logic             last_of_run;
	logic             grid_end;

	modport source (output valid, output cell_row, output cell_col, output is_peak,
		output last_of_run, output grid_end, input ready);
	modport sink (input valid, input cell_row, input cell_col, input is_peak,
		input last_of_run, input grid_end, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/grid_local_maximum_finder.sv =====
`default_nettype none
// Streams a grid of signed values in row-major order, one value per beat, and reports for each
// cell whether it is at least every up, down, left and right neighbour inside the grid. An input
// beat can be taken every cycle while the result queue has room; it is registered, compared
// against a two-row column history held in a dual-read RAM and against the two previous values
// of its row, and its zero to three result beats go from that register into an eight-entry queue.
// Result beats leave at one per cycle while the receiver is ready, and along the last row, which
// can give up to three results per input, the output side sets the pace. Writing either count
// register restarts the grid at row 0, column 0; counts of 0 read as 1 and counts above 32 as 32.
module grid_local_maximum_finder import glmf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	glmf_in_if.sink          in_chan,
	glmf_out_if.source       out_chan
);

	localparam int HIST_W = 2 * VALUE_WIDTH;

	logic [CNT_W-1:0]  row_count_q;
	logic [CNT_W-1:0]  col_count_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]  cur_col_q;
	logic              cfg_wr;
	logic [CNT_W-1:0]  wr_val;
	logic [CNT_W-1:0]  clamped;
	reg_index_t        wr_idx;
	logic              in_acc;

	logic              valid_s1;
	value_t            x_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [COL_W-1:0]  col_s1;
	logic              hit_a_q;
	logic              hit_b_q;
	logic [HIST_W-1:0] byp_q;
	value_t            left1_q;
	value_t            left2_q;
	value_t            prev_left_q;

	logic [HIST_W-1:0] ram_a;
	logic [HIST_W-1:0] ram_b;
	logic [HIST_W-1:0] hist_a;
	logic [HIST_W-1:0] hist_b;
	value_t            up2;
	value_t            up1;
	value_t            up_right;
	logic [CNT_W-1:0]  r6;
	logic [CNT_W-1:0]  c6;
	logic              last_row;
	logic              last_col;
	logic [2:0]        res_valid;
	logic [2:0]        res_peak;
	logic [ROW_W-1:0]  res_row [RES_PER_IN];
	logic [COL_W-1:0]  res_col [RES_PER_IN];
	push_t             push;
	fifo_status_t      fifo_status;
	logic [FIFO_CNT_W-1:0] push_n;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign wr_idx = reg_index_t'(paddr[2]);
	assign wr_val = pwdata[CNT_W-1:0];

	always_comb begin
		if (wr_val == '0) begin
			clamped = CNT_W'(1);
		end else if (wr_val > CNT_W'(MAX_ROWS)) begin
			clamped = CNT_W'(MAX_ROWS);
		end else begin
			clamped = wr_val;
		end
	end

	always_comb begin
		case (wr_idx)
			REG_ROW_COUNT: prdata = {{(32-CNT_W){1'b0}}, row_count_q};
			REG_COL_COUNT: prdata = {{(32-CNT_W){1'b0}}, col_count_q};
			default:       prdata = '0;
		endcase
	end

	// Input side: room for a full set of results must remain after the item in stage one.
	assign push_n       = FIFO_CNT_W'(res_valid[0]) + FIFO_CNT_W'(res_valid[1])
		+ FIFO_CNT_W'(res_valid[2]);
	assign in_chan.ready = (fifo_status.fill + push_n) <= FIFO_CNT_W'(FIFO_DEPTH - RES_PER_IN);
	assign in_acc        = in_chan.valid && in_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= CNT_W'(MAX_ROWS);
			col_count_q <= CNT_W'(MAX_COLS);
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			valid_s1    <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
			if (cfg_wr) begin
				case (wr_idx)
					REG_ROW_COUNT: row_count_q <= clamped;
					REG_COL_COUNT: col_count_q <= clamped;
					default: ;
				endcase
				cur_row_q <= '0;
				cur_col_q <= '0;
			end else if (in_acc) begin
				if ({1'b0, cur_col_q} + CNT_W'(1) >= col_count_q) begin
					cur_col_q <= '0;
					if ({1'b0, cur_row_q} + CNT_W'(1) >= row_count_q) begin
						cur_row_q <= '0;
					end else begin
						cur_row_q <= cur_row_q + ROW_W'(1);
					end
				end else begin
					cur_col_q <= cur_col_q + COL_W'(1);
				end
			end
		end
	end

	// Stage one payload and the write-through path for a column being rewritten.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_s1    <= in_chan.value;
			row_s1  <= cur_row_q;
			col_s1  <= cur_col_q;
			hit_a_q <= valid_s1 && (col_s1 == cur_col_q);
			hit_b_q <= valid_s1 && (col_s1 == cur_col_q + COL_W'(1));
			byp_q   <= {up1, x_s1};
		end
		if (valid_s1) begin
			left1_q     <= x_s1;
			left2_q     <= left1_q;
			prev_left_q <= up1;
		end
	end

	// Each entry holds the two latest rows of one column: older in the upper half.
	glmf_ram #(
		.WIDTH (HIST_W),
		.DEPTH (MAX_COLS)
	) u_hist (
		.clk     (clk),
		.wen     (valid_s1),
		.waddr   (col_s1),
		.wdata   ({up1, x_s1}),
		.raddr_a (cur_col_q),
		.raddr_b (cur_col_q + COL_W'(1)),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	assign hist_a   = hit_a_q ? byp_q : ram_a;
	assign hist_b   = hit_b_q ? byp_q : ram_b;
	assign up2      = hist_a[HIST_W-1:VALUE_WIDTH];
	assign up1      = hist_a[VALUE_WIDTH-1:0];
	assign up_right = hist_b[VALUE_WIDTH-1:0];

	assign r6       = {1'b0, row_s1};
	assign c6       = {1'b0, col_s1};
	assign last_row = (r6 == row_count_q - CNT_W'(1));
	assign last_col = (c6 == col_count_q - CNT_W'(1));

	always_comb begin
		// Cell above, whose down neighbour is this beat.
		res_valid[0] = valid_s1 && (row_s1 != '0);
		res_row[0]   = row_s1 - ROW_W'(1);
		res_col[0]   = col_s1;
		res_peak[0]  = (up1 >= x_s1)
			&& !((r6 >= CNT_W'(2)) && (up1 < up2))
			&& !((col_s1 != '0) && (up1 < prev_left_q))
			&& !((c6 + CNT_W'(1) < col_count_q) && (up1 < up_right));
		// Cell to the left on the last row, whose right neighbour is this beat.
		res_valid[1] = valid_s1 && last_row && (col_s1 != '0);
		res_row[1]   = row_s1;
		res_col[1]   = col_s1 - COL_W'(1);
		res_peak[1]  = (left1_q >= x_s1)
			&& !((row_s1 != '0) && (left1_q < prev_left_q))
			&& !((c6 >= CNT_W'(2)) && (left1_q < left2_q));
		// The final cell settles itself.
		res_valid[2] = valid_s1 && last_row && last_col;
		res_row[2]   = row_s1;
		res_col[2]   = col_s1;
		res_peak[2]  = !((row_s1 != '0) && (x_s1 < up1))
			&& !((col_s1 != '0) && (x_s1 < left1_q));

		push.valid = res_valid;
		for (int k = 0; k < RES_PER_IN; k++) begin
			push.entry[k].cell_row    = res_row[k];
			push.entry[k].cell_col    = res_col[k];
			push.entry[k].is_peak     = res_peak[k];
			push.entry[k].grid_end    = ({1'b0, res_row[k]} == row_count_q - CNT_W'(1))
				&& ({1'b0, res_col[k]} == col_count_q - CNT_W'(1));
			push.entry[k].last_of_run = 1'b0;
		end
		if (res_valid[2]) begin
			push.entry[2].last_of_run = 1'b1;
		end else if (res_valid[1]) begin
			push.entry[1].last_of_run = 1'b1;
		end else if (res_valid[0]) begin
			push.entry[0].last_of_run = 1'b1;
		end
	end

	glmf_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.status   (fifo_status),
		.out_chan (out_chan)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (FIFO_CNT_W'(fifo_status.fill) + push_n) <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("Result queue overflow.");

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (cur_row_q == '0) && (cur_col_q == '0))
		else $error("Grid position not restarted after a register write.");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("Accepted beat did not reach stage one.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_row && last_col) |-> $countones(res_valid) != 0)
		else $error("Final grid cell produced no result.");

endmodule
`default_nettype wire

// ===== hw/rtl/glmf_ram.sv =====
`default_nettype none
module glmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wen,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/glmf_result_fifo.sv =====
`default_nettype none
module glmf_result_fifo import glmf_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire push_t        push,
	output fifo_status_t      status,
	glmf_out_if.source        out_chan
);

	result_t                 fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_CNT_W-1:0]   count_q;
	logic [FIFO_PTR_W-1:0]   slot [RES_PER_IN];
	logic [FIFO_CNT_W-1:0]   push_n;
	logic                    pop;
	result_t                 head;

	// Valid results are packed into consecutive slots, keeping their order.
	always_comb begin
		slot[0] = wr_ptr_q;
		slot[1] = wr_ptr_q + FIFO_PTR_W'(push.valid[0]);
		slot[2] = wr_ptr_q + FIFO_PTR_W'(push.valid[0]) + FIFO_PTR_W'(push.valid[1]);
		push_n  = FIFO_CNT_W'(push.valid[0]) + FIFO_CNT_W'(push.valid[1])
			+ FIFO_CNT_W'(push.valid[2]);
	end

	assign pop  = out_chan.valid && out_chan.ready;
	assign head = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int k = 0; k < RES_PER_IN; k++) begin
			if (push.valid[k]) begin
				fifo_q[slot[k]] <= push.entry[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + push_n - FIFO_CNT_W'(pop);
		end
	end

	assign status.fill          = count_q;
	assign out_chan.valid       = (count_q != '0);
	assign out_chan.cell_row    = head.cell_row;
	assign out_chan.cell_col    = head.cell_col;
	assign out_chan.is_peak     = head.is_peak;
	assign out_chan.last_of_run = head.last_of_run;
	assign out_chan.grid_end    = head.grid_end;

endmodule
`default_nettype wire

// ===== verif/grid_local_maximum_finder_checker.sv =====
module grid_local_maximum_finder_checker import glmf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	glmf_in_if               in_chan,
	glmf_out_if              out_chan,
	output int               pending,
	output int               errors
);

	value_t      history [2][MAX_COLS];
	int unsigned row_ptr;
	int unsigned col_ptr;
	int unsigned n_rows;
	int unsigned n_cols;
	result_t     pending_cells[$];

	function automatic int unsigned count_setting(logic [31:0] word, int unsigned limit);
		int unsigned v;
		v = 32'(word[CNT_W-1:0]);
		if (v == 0) begin
			return 1;
		end
		if (v > limit) begin
			return limit;
		end
		return v;
	endfunction

	function automatic result_t cell_result(int unsigned r, int unsigned c, logic peak);
		result_t res;
		res.cell_row    = ROW_W'(r);
		res.cell_col    = COL_W'(c);
		res.is_peak     = peak;
		res.last_of_run = 1'b0;
		res.grid_end    = (r == n_rows - 1) && (c == n_cols - 1);
		return res;
	endfunction

	function automatic void decide_cells(value_t x);
		int unsigned r;
		int unsigned c;
		int unsigned cb;
		int unsigned pb;
		logic        bottom;
		logic        peak;
		value_t      s;
		result_t     batch[$];
		r = row_ptr;
		c = col_ptr;
		cb = r % 2;
		pb = (r + 1) % 2;
		bottom = (r == n_rows - 1);
		if (r >= 1) begin
			s = history[pb][c];
			peak = (s >= x);
			if (r >= 2 && s < history[cb][c]) peak = 1'b0;
			if (c >= 1 && s < history[pb][c-1]) peak = 1'b0;
			if (c + 1 < n_cols && s < history[pb][c+1]) peak = 1'b0;
			batch.push_back(cell_result(r - 1, c, peak));
		end
		if (bottom && c >= 1) begin
			s = history[cb][c-1];
			peak = (s >= x);
			if (r >= 1 && s < history[pb][c-1]) peak = 1'b0;
			if (c >= 2 && s < history[cb][c-2]) peak = 1'b0;
			batch.push_back(cell_result(r, c - 1, peak));
		end
		if (bottom && c == n_cols - 1) begin
			peak = 1'b1;
			if (r >= 1 && x < history[pb][c]) peak = 1'b0;
			if (c >= 1 && x < history[cb][c-1]) peak = 1'b0;
			batch.push_back(cell_result(r, c, peak));
		end
		history[cb][c] = x;
		if (c + 1 >= n_cols) begin
			col_ptr = 0;
			row_ptr = (r + 1 >= n_rows) ? 0 : r + 1;
		end else begin
			col_ptr = c + 1;
		end
		if (batch.size() > 0) begin
			batch[batch.size()-1].last_of_run = 1'b1;
		end
		foreach (batch[i]) begin
			pending_cells.push_back(batch[i]);
		end
	endfunction

	task automatic flag(string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	task automatic match_field(string name, logic [4:0] got, logic [4:0] want, result_t item);
		if (got !== want) begin
			flag($sformatf("%s of cell (%0d,%0d): got %0d, expected %0d",
				name, item.cell_row, item.cell_col, got, want));
		end
	endtask

	task automatic check_beat();
		result_t want;
		if (pending_cells.size() == 0) begin
			flag($sformatf("beat for cell (%0d,%0d) with nothing outstanding",
				out_chan.cell_row, out_chan.cell_col));
		end else begin
			want = pending_cells.pop_front();
			match_field("cell_row", out_chan.cell_row, want.cell_row, want);
			match_field("cell_col", out_chan.cell_col, want.cell_col, want);
			match_field("is_peak", 5'(out_chan.is_peak), 5'(want.is_peak), want);
			match_field("last_of_run", 5'(out_chan.last_of_run), 5'(want.last_of_run), want);
			match_field("grid_end", 5'(out_chan.grid_end), 5'(want.grid_end), want);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (history[i, j]) history[i][j] = '0;
			row_ptr = 0;
			col_ptr = 0;
			n_rows = MAX_ROWS;
			n_cols = MAX_COLS;
			pending_cells.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
				case (reg_index_t'(paddr[2]))
					REG_ROW_COUNT: n_rows = count_setting(pwdata, MAX_ROWS);
					REG_COL_COUNT: n_cols = count_setting(pwdata, MAX_COLS);
					default: ;
				endcase
				row_ptr = 0;
				col_ptr = 0;
			end
			if (in_chan.valid === 1'b1 && in_chan.ready === 1'b1) begin
				decide_cells(in_chan.value);
			end
			if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
				check_beat();
			end
			pending <= pending_cells.size();
		end
	end

endmodule

// ===== verif/grid_local_maximum_finder_test.sv =====
module grid_local_maximum_finder_test;
	import glmf_pkg::*;

	localparam int          SETTLE_CYCLES = 12;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int          RANDOM_ITEMS  = 350;
	localparam int          QUIET_FROM    = 290;
	localparam int          LONG_HOLD     = 70;
	localparam value_t      VMAX          = 16'sh7fff;
	localparam value_t      VMIN          = 16'sh8000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          pending;
	int          errors;
	logic        quiet;
	logic        hold_go;
	logic        hold_prev = 1'b0;
	bit          sender_lazy;
	bit          receiver_lazy = 1'b1;
	int unsigned cycles = 0;
	int          hold_left = 0;
	int          ready_gap = 0;
	int          mode_left = 0;
	int          random_sent;
	value_t      script[$];

	glmf_in_if  in_chan ();
	glmf_out_if out_chan ();

	grid_local_maximum_finder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_chan  (in_chan),
		.out_chan (out_chan)
	);

	grid_local_maximum_finder_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.pready   (pready),
		.in_chan  (in_chan),
		.out_chan (out_chan),
		.pending  (pending),
		.errors   (errors)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("grid_local_maximum_finder_test: done, errors");
			$finish;
		end
	end

	// A rising hold_go makes the receiver refuse beats for a long stretch.
	always @(posedge clk) begin
		hold_prev <= hold_go;
		if (hold_go && !hold_prev) begin
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_chan.ready <= 1'b0;
		end else if (ready_gap > 0) begin
			ready_gap--;
			out_chan.ready <= 1'b0;
		end else if (!quiet && receiver_lazy && $urandom_range(0, 3) == 0) begin
			ready_gap = $urandom_range(1, 5) - 1;
			out_chan.ready <= 1'b0;
		end else begin
			out_chan.ready <= 1'b1;
		end
		if (mode_left == 0) begin
			mode_left = 150;
			receiver_lazy = $urandom_range(0, 2) != 0;
		end else begin
			mode_left--;
		end
	end

	function automatic value_t random_value();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1, 2, 3, 4: return value_t'($urandom_range(0, 6) - 3);
			5: return VMAX;
			6: return VMIN;
			default: return value_t'($urandom());
		endcase
	endfunction

	task automatic send(value_t v);
		int gap;
		if (!quiet && sender_lazy && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_chan.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_chan.valid <= 1'b1;
		in_chan.value <= v;
		do @(posedge clk); while (in_chan.ready !== 1'b1);
	endtask

	task automatic settle();
		in_chan.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(logic [31:0] rows_word, logic [31:0] cols_word);
		settle();
		write_reg(REG_ROW_COUNT, rows_word);
		write_reg(REG_COL_COUNT, cols_word);
	endtask

	task automatic play_script(logic [31:0] rows_word, logic [31:0] cols_word);
		configure(rows_word, cols_word);
		foreach (script[i]) send(script[i]);
	endtask

	task automatic run_random(logic [31:0] rows_word, logic [31:0] cols_word, int count);
		configure(rows_word, cols_word);
		sender_lazy = $urandom_range(0, 2) != 0;
		repeat (count) begin
			if (random_sent >= QUIET_FROM) quiet <= 1'b1;
			send(random_value());
			random_sent++;
		end
	endtask

	initial begin
		int r;
		int c;
		int n;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_chan.valid = 1'b0;
		in_chan.value = '0;
		out_chan.ready = 1'b0;
		quiet = 1'b0;
		hold_go = 1'b0;
		random_sent = 0;
		sender_lazy = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// A count of zero reads as one, so every value here is a single-cell grid.
		script = '{VMAX, VMIN, 0};
		play_script(32'd0, 32'd1);
		script = '{5, 5, -1, 5};
		play_script(32'd1, 32'd4);
		script = '{VMIN, VMIN, 7};
		play_script(32'd3, 32'd1);
		script = '{VMAX, VMIN, VMAX, VMIN, 0, VMIN, 1, 1, 1};
		play_script(32'd3, 32'd3);

		// One long row gives as many beats as inputs, so a stalled receiver fills the queue.
		configure(32'd1, 32'd32);
		hold_go <= 1'b1;
		sender_lazy = 1'b0;
		repeat (40) begin
			send(random_value());
			random_sent++;
		end
		hold_go <= 1'b0;

		run_random(32'd32, 32'd2, 66);
		run_random(32'd2, 32'd32, 66);
		run_random(32'd63, 32'd1, 34);
		run_random(32'd45, 32'd45, 36);
		while (random_sent < RANDOM_ITEMS) begin
			r = $urandom_range(1, 6);
			c = $urandom_range(1, 8);
			n = r * c * $urandom_range(1, 2) + $urandom_range(0, r * c);
			if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
			run_random(r, c, n);
		end

		settle();
		if (errors == 0) begin
			$display("grid_local_maximum_finder_test: done, clean");
		end else begin
			$display("grid_local_maximum_finder_test: done, errors");
		end
		$finish;
	end

endmodule
